>>> rtl/ojg_pkg.sv
// ----------------------------------------------------------------------------
// ojg_pkg
// Shared widths, lane structs and latency figures for the optimal Jacobian
// pipeline.
// ----------------------------------------------------------------------------
package ojg_pkg;

    localparam int FRAC_BITS = 12;
    localparam int UNIT_BITS = 28;
    localparam int DW        = 16;            // port field width
    localparam int VW        = 18;            // column component, signed
    localparam int LEN_W     = 16;            // column length / geometric mean
    localparam int SQ_IN_W   = 32;            // squared column length

    // square root cell: one root bit per cell
    localparam int SQ_RAD_W  = 60;
    localparam int SQ_RT_W   = 30;
    localparam int SQ_REM_W  = SQ_RT_W + 1;
    localparam int SQ_T_W    = SQ_REM_W + 2;

    // divider cell: one quotient bit per cell
    localparam int DIV_DEN_W = 30;
    localparam int DIV_Q_W   = UNIT_BITS + 1;

    localparam int SQ1_CELLS  = SQ_IN_W / 2;
    localparam int DIV1_CELLS = UNIT_BITS + 1;
    localparam int SQ2_CELLS  = SQ_RT_W;
    localparam int DIV2_CELLS = LEN_W + 1;

    localparam int DX_W  = UNIT_BITS + 3;     // sum of two unit components, signed
    localparam int N1_W  = LEN_W + UNIT_BITS + 1;
    localparam int N2_W  = DIV_DEN_W + LEN_W + 1;

    localparam int COL_LAT = 1 + SQ1_CELLS + 1 + DIV1_CELLS + 1 + 1 + SQ2_CELLS + 1
                           + DIV2_CELLS + 1;

    typedef struct packed {
        logic [SQ_RAD_W-1:0] rad;
        logic [SQ_REM_W-1:0] rem;
        logic [SQ_RT_W-1:0]  root;
    } sq_lane_t;

    typedef struct packed {
        logic [DIV_Q_W-1:0]   dvd;
        logic [DIV_DEN_W-1:0] rem;
        logic [DIV_DEN_W-1:0] den;
        logic [DIV_Q_W-1:0]   quo;
    } div_lane_t;

    typedef struct packed {
        logic signed [VW-1:0] ux;
        logic signed [VW-1:0] uy;
        logic signed [VW-1:0] vx;
        logic signed [VW-1:0] vy;
    } col_vec_t;

    typedef struct packed {
        logic signed [DW-1:0] ox;
        logic signed [DW-1:0] oy;
        logic                 ok;
    } col_res_t;

endpackage

>>> rtl/ojg_sqrt_cell.sv
// ----------------------------------------------------------------------------
// ojg_sqrt_cell
// One step of a restoring square root: takes two radicand bits, yields one
// root bit and hands the lane to the next cell.
// ----------------------------------------------------------------------------
module ojg_sqrt_cell
(
    input  logic              clk,
    input  logic              en,
    input  ojg_pkg::sq_lane_t d,
    output ojg_pkg::sq_lane_t q
);
    import ojg_pkg::*;

    logic [SQ_T_W-1:0] t;
    logic [SQ_T_W-1:0] trial;
    logic              ge;
    logic [SQ_T_W-1:0] diff;
    sq_lane_t          nxt;

    always_comb
    begin
        t     = {d.rem, d.rad[SQ_RAD_W-1 -: 2]};
        trial = {1'b0, d.root, 2'b01};
        ge    = (t >= trial);
        diff  = t - trial;
        nxt.rad  = {d.rad[SQ_RAD_W-3:0], 2'b00};
        nxt.rem  = ge ? diff[SQ_REM_W-1:0] : t[SQ_REM_W-1:0];
        nxt.root = {d.root[SQ_RT_W-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q <= nxt;
        end
    end

endmodule

>>> rtl/ojg_div_cell.sv
// ----------------------------------------------------------------------------
// ojg_div_cell
// One step of a restoring divider: shifts in one dividend bit and settles
// one quotient bit.
// ----------------------------------------------------------------------------
module ojg_div_cell
(
    input  logic               clk,
    input  logic               en,
    input  ojg_pkg::div_lane_t d,
    output ojg_pkg::div_lane_t q
);
    import ojg_pkg::*;

    logic [DIV_DEN_W:0] t;
    logic [DIV_DEN_W:0] diff;
    logic               ge;
    div_lane_t          nxt;

    always_comb
    begin
        t    = {d.rem, d.dvd[DIV_Q_W-1]};
        ge   = (t >= {1'b0, d.den});
        diff = t - {1'b0, d.den};
        nxt.dvd = {d.dvd[DIV_Q_W-2:0], 1'b0};
        nxt.rem = ge ? diff[DIV_DEN_W-1:0] : t[DIV_DEN_W-1:0];
        nxt.den = d.den;
        nxt.quo = {d.quo[DIV_Q_W-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q <= nxt;
        end
    end

endmodule

>>> rtl/ojg_column.sv
// ----------------------------------------------------------------------------
// ojg_column
// Optimal column from one column of I-G and one of I+G: lengths, unit
// vectors, direction length, geometric mean and final scaling, all as chains
// of root and divider cells.
// ----------------------------------------------------------------------------
module ojg_column
(
    input  logic              clk,
    input  logic              en,
    input  ojg_pkg::col_vec_t vin,
    output ojg_pkg::col_res_t res
);
    import ojg_pkg::*;

    typedef struct packed {
        logic [LEN_W-1:0] lu;
        logic [LEN_W-1:0] lv;
        logic [3:0]       neg;
        logic             ok;
    } side2_t;

    typedef struct packed {
        logic signed [DX_W-1:0] dx;
        logic signed [DX_W-1:0] dy;
        logic                   ok;
    } side3_t;

    typedef struct packed {
        logic sx;
        logic sy;
        logic ok;
    } side4_t;

    // unit component setup: (|c| << UNIT_BITS) + len/2, split for the divider
    function automatic div_lane_t unit_setup(input logic signed [VW-1:0] c,
                                             input logic [LEN_W-1:0] len);
        logic [VW-1:0]    mag;
        logic [LEN_W-1:0] den;
        logic [N1_W-1:0]  n;
        div_lane_t        l;
        mag   = c[VW-1] ? VW'(-c) : VW'(c);
        den   = (len == '0) ? LEN_W'(1) : len;
        n     = {mag[LEN_W:0], UNIT_BITS'(0)} + N1_W'(den >> 1);
        l.rem = DIV_DEN_W'(n[N1_W-1:DIV1_CELLS]);
        l.dvd = n[DIV1_CELLS-1:0];
        l.den = DIV_DEN_W'(den);
        l.quo = '0;
        return l;
    endfunction

    function automatic logic signed [DX_W-1:0] apply_sign(input logic [DIV_Q_W-1:0] m,
                                                          input logic neg);
        logic signed [DX_W-1:0] v;
        v = signed'(DX_W'(m));
        return neg ? -v : v;
    endfunction

    function automatic logic signed [DW-1:0] sat_out(input logic [DIV2_CELLS-1:0] m,
                                                     input logic neg);
        logic signed [DW-1:0] v;
        if (neg)
        begin
            v = (m > DIV2_CELLS'(32768)) ? DW'(16'sh8000) : DW'(-m);
        end
        else
        begin
            v = (m > DIV2_CELLS'(32767)) ? DW'(16'sh7fff) : DW'(m);
        end
        return v;
    endfunction

    // stage A: squared lengths
    logic signed [2*VW-1:0] pux, puy, pvx, pvy;
    logic signed [2*VW:0]   su_sum, sv_sum;

    always_comb
    begin
        pux    = vin.ux * vin.ux;
        puy    = vin.uy * vin.uy;
        pvx    = vin.vx * vin.vx;
        pvy    = vin.vy * vin.vy;
        su_sum = (2*VW+1)'(pux) + (2*VW+1)'(puy);
        sv_sum = (2*VW+1)'(pvx) + (2*VW+1)'(pvy);
    end

    sq_lane_t sq1u [SQ1_CELLS+1];
    sq_lane_t sq1v [SQ1_CELLS+1];
    col_vec_t side1 [SQ1_CELLS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq1u[0]  <= '{rad: {su_sum[SQ_IN_W-1:0], (SQ_RAD_W-SQ_IN_W)'(0)},
                          rem: '0, root: '0};
            sq1v[0]  <= '{rad: {sv_sum[SQ_IN_W-1:0], (SQ_RAD_W-SQ_IN_W)'(0)},
                          rem: '0, root: '0};
            side1[0] <= vin;
        end
    end

    for (genvar i = 0; i < SQ1_CELLS; i++)
    begin : g_sq1
        ojg_sqrt_cell u_cu (.clk(clk), .en(en), .d(sq1u[i]), .q(sq1u[i+1]));
        ojg_sqrt_cell u_cv (.clk(clk), .en(en), .d(sq1v[i]), .q(sq1v[i+1]));
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side1[i+1] <= side1[i];
            end
        end
    end

    // stage B: unit vector divisions
    logic [LEN_W-1:0] lu, lv;
    col_vec_t         s1;
    assign lu = sq1u[SQ1_CELLS].root[LEN_W-1:0];
    assign lv = sq1v[SQ1_CELLS].root[LEN_W-1:0];
    assign s1 = side1[SQ1_CELLS];

    div_lane_t dl [4][DIV1_CELLS+1];
    side2_t    side2 [DIV1_CELLS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dl[0][0] <= unit_setup(s1.ux, lu);
            dl[1][0] <= unit_setup(s1.vx, lv);
            dl[2][0] <= unit_setup(s1.uy, lu);
            dl[3][0] <= unit_setup(s1.vy, lv);
            side2[0] <= '{lu: lu, lv: lv,
                          neg: {s1.vy[VW-1], s1.uy[VW-1], s1.vx[VW-1], s1.ux[VW-1]},
                          ok: (lu != '0) && (lv != '0)};
        end
    end

    for (genvar i = 0; i < DIV1_CELLS; i++)
    begin : g_div1
        for (genvar k = 0; k < 4; k++)
        begin : g_lane
            ojg_div_cell u_c (.clk(clk), .en(en), .d(dl[k][i]), .q(dl[k][i+1]));
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side2[i+1] <= side2[i];
            end
        end
    end

    // stage C: direction and length product
    side2_t                 s2;
    logic signed [DX_W-1:0] dx_c, dy_c;
    assign s2   = side2[DIV1_CELLS];
    assign dx_c = apply_sign(dl[0][DIV1_CELLS].quo, s2.neg[0])
                + apply_sign(dl[1][DIV1_CELLS].quo, s2.neg[1]);
    assign dy_c = apply_sign(dl[2][DIV1_CELLS].quo, s2.neg[2])
                + apply_sign(dl[3][DIV1_CELLS].quo, s2.neg[3]);

    side3_t            c_reg;
    logic [SQ_IN_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg    <= '{dx: dx_c, dy: dy_c, ok: s2.ok};
            prod_reg <= s2.lu * s2.lv;
        end
    end

    // stage D: squared direction
    logic signed [2*DX_W-1:0] pdx, pdy;
    logic [2*DX_W-1:0]        sd;
    assign pdx = c_reg.dx * c_reg.dx;
    assign pdy = c_reg.dy * c_reg.dy;
    assign sd  = unsigned'(pdx) + unsigned'(pdy);

    sq_lane_t sqd [SQ2_CELLS+1];
    sq_lane_t sqg [SQ2_CELLS+1];
    side3_t   side3 [SQ2_CELLS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqd[0]   <= '{rad: sd[SQ_RAD_W-1:0], rem: '0, root: '0};
            sqg[0]   <= '{rad: SQ_RAD_W'(prod_reg), rem: '0, root: '0};
            side3[0] <= c_reg;
        end
    end

    for (genvar i = 0; i < SQ2_CELLS; i++)
    begin : g_sq2
        ojg_sqrt_cell u_cd (.clk(clk), .en(en), .d(sqd[i]), .q(sqd[i+1]));
        ojg_sqrt_cell u_cg (.clk(clk), .en(en), .d(sqg[i]), .q(sqg[i+1]));
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side3[i+1] <= side3[i];
            end
        end
    end

    // stage F: final scaling dividends
    side3_t               s3;
    logic [SQ_RT_W-1:0]   ld, den2;
    logic [LEN_W-1:0]     gm;
    logic [DX_W-1:0]      mdx, mdy;
    logic [N2_W-1:0]      nx, ny;

    always_comb
    begin
        s3   = side3[SQ2_CELLS];
        ld   = sqd[SQ2_CELLS].root;
        gm   = sqg[SQ2_CELLS].root[LEN_W-1:0];
        den2 = (ld == '0) ? SQ_RT_W'(1) : ld;
        mdx  = s3.dx[DX_W-1] ? DX_W'(-s3.dx) : DX_W'(s3.dx);
        mdy  = s3.dy[DX_W-1] ? DX_W'(-s3.dy) : DX_W'(s3.dy);
        nx   = N2_W'(mdx[DIV_DEN_W-1:0] * gm) + N2_W'(den2 >> 1);
        ny   = N2_W'(mdy[DIV_DEN_W-1:0] * gm) + N2_W'(den2 >> 1);
    end

    div_lane_t dx2 [DIV2_CELLS+1];
    div_lane_t dy2 [DIV2_CELLS+1];
    side4_t    side4 [DIV2_CELLS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx2[0]   <= '{dvd: {nx[DIV2_CELLS-1:0], (DIV_Q_W-DIV2_CELLS)'(0)},
                          rem: nx[N2_W-1:DIV2_CELLS], den: den2, quo: '0};
            dy2[0]   <= '{dvd: {ny[DIV2_CELLS-1:0], (DIV_Q_W-DIV2_CELLS)'(0)},
                          rem: ny[N2_W-1:DIV2_CELLS], den: den2, quo: '0};
            side4[0] <= '{sx: s3.dx[DX_W-1], sy: s3.dy[DX_W-1],
                          ok: s3.ok && (ld != '0)};
        end
    end

    for (genvar i = 0; i < DIV2_CELLS; i++)
    begin : g_div2
        ojg_div_cell u_cx (.clk(clk), .en(en), .d(dx2[i]), .q(dx2[i+1]));
        ojg_div_cell u_cy (.clk(clk), .en(en), .d(dy2[i]), .q(dy2[i+1]));
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side4[i+1] <= side4[i];
            end
        end
    end

    // stage G: sign and saturation
    side4_t s4;
    assign s4 = side4[DIV2_CELLS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res.ox <= sat_out(dx2[DIV2_CELLS].quo[DIV2_CELLS-1:0], s4.sx);
            res.oy <= sat_out(dy2[DIV2_CELLS].quo[DIV2_CELLS-1:0], s4.sy);
            res.ok <= s4.ok;
        end
    end

endmodule

>>> rtl/optimal_jacobian_from_gradients_unit.sv
// The valid bits run in step with the data through ojg_pkg::COL_LAT registers.
// Throughput: one pixel per cycle unless the result stalls; the two columns
// run as parallel chains of root and divider cells, each settling one bit per
// cycle. A stalled result beat freezes the whole chain and drops s_tready.
// Reset (rst_n, async, active low) clears the valid bits only.
// ----------------------------------------------------------------------------
// optimal_jacobian_from_gradients_unit
// Per-pixel optimal Jacobian from the four displacement differences, Q4.12.
// ----------------------------------------------------------------------------
module optimal_jacobian_from_gradients_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // dux_dx, duy_dx, dux_dy, duy_dy
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // col_a_x, col_b_x, col_a_y, col_b_y
    output logic        m_tuser    // degenerate
);
    import ojg_pkg::*;

    localparam logic signed [VW-1:0] ONE = VW'(1) <<< FRAC_BITS;

    logic                 en;
    logic [COL_LAT-1:0]   valid_reg;
    logic signed [VW-1:0] gxx, gyx, gxy, gyy;
    col_vec_t             va, vb;
    col_res_t             ra, rb;
    logic                 degen;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign m_tvalid = valid_reg[COL_LAT-1];

    assign gxx = VW'(signed'(s_tdata[15:0]));
    assign gyx = VW'(signed'(s_tdata[31:16]));
    assign gxy = VW'(signed'(s_tdata[47:32]));
    assign gyy = VW'(signed'(s_tdata[63:48]));

    assign va = '{ux: ONE - gxx, uy: -gyx, vx: ONE + gxx, vy: gyx};
    assign vb = '{ux: -gxy, uy: ONE - gyy, vx: gxy, vy: ONE + gyy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[COL_LAT-2:0], s_tvalid};
        end
    end

    ojg_column u_col_a (.clk(clk), .en(en), .vin(va), .res(ra));
    ojg_column u_col_b (.clk(clk), .en(en), .vin(vb), .res(rb));

    assign degen   = !(ra.ok && rb.ok);
    assign m_tuser = degen;
    assign m_tdata = degen ? '0 : {rb.oy, ra.oy, rb.ox, ra.ox};

endmodule
